// File: rtl/mtcd_pkg.sv
`default_nettype none

package mtcd_pkg;

   // Wheel and timer constants.
   localparam int MULT_FACTOR  = 8;
   localparam int CAPTURE_SPAN = 65536;
   localparam int TICK_LIMIT   = 2 * MULT_FACTOR;

   // Configuration reset values.
   localparam logic [7:0]  MIN_TEETH_RESET   = 8'd30;
   localparam logic [15:0] MARKER_ON_RESET   = 16'd10;
   localparam logic [15:0] MARKER_OFF_RESET  = 16'd20;
   localparam logic [15:0] MULT_RELOAD_RESET = 16'hFFFF;

   // Result word layout, lowest bit first.
   localparam int RSP_LOCKED_LSB = 0;
   localparam int RSP_ANGLE_LSB  = 1;
   localparam int RSP_MARKER_LSB = 17;
   localparam int RSP_LAMP_LSB   = 18;
   localparam int RSP_GOOD_LSB   = 19;
   localparam int RSP_BAD_LSB    = 27;
   localparam int RSP_BITS       = 35;
   localparam int RSP_DATA_W     = 40;

   typedef enum logic [1:0] {
      REQ_EDGE     = 2'd0,
      REQ_OVERFLOW = 2'd1,
      REQ_TICK     = 2'd2,
      REQ_UNUSED   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_MIN_TEETH   = 2'd0,
      CSR_MARKER_ON   = 2'd1,
      CSR_MARKER_OFF  = 2'd2,
      CSR_MULT_RELOAD = 2'd3
   } csr_index_type;

endpackage

`default_nettype wire

// File: rtl/missing_tooth_crank_decoder.sv
// Channel    | Direction | Payload
// req_       | in        | tuser: request kind (2); tdata: capture_time (16)
// rsp_       | out       | tdata: locked, angle, marker, lamp, good teeth, bad teeth
// csr_       | in/out    | APB registers at byte addresses 0, 4, 8, 12
//
// Each request decodes combinationally; the wheel state and result register are
// updated at the edge it is taken, so one request per cycle unless rsp_ stalls.
// Reset is synchronous: live reload and registers get defaults, all else clears.
// A stalled result holds the result register; a new request is taken in the same
// cycle the held result is taken, so no bubble appears under back pressure.
`default_nettype none

module missing_tooth_crank_decoder
   import mtcd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [15:0]           req_tdata,   // [15:0] capture_time
   input  wire logic [1:0]            req_tuser,   // [1:0] req_type
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [0] sync_locked, [16:1] crank_angle, [17] marker_level, [18] check_lamp,
   // [26:19] good_sync_teeth, [34:27] bad_sync_teeth, [39:35] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [3:0]            csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   // Configuration registers.
   logic [7:0]  min_teeth_ff;
   logic [15:0] marker_on_ff;
   logic [15:0] marker_off_ff;
   logic [15:0] init_reload_ff;

   // Wheel state.
   logic [15:0] start_stamp_ff,  start_stamp_in;
   logic [15:0] overflow_ff,     overflow_in;
   logic        edge_phase_ff,   edge_phase_in;
   logic [7:0]  ticks_ff,        ticks_in;
   logic [7:0]  teeth_ff,        teeth_in;
   logic        locked_ff,       locked_in;
   logic [7:0]  good_ff,         good_in;
   logic [7:0]  bad_ff,          bad_in;
   logic [15:0] angle_ff,        angle_in;
   logic [15:0] reload_ff,       reload_in;
   logic [15:0] mult_count_ff,   mult_count_in;
   logic        marker_ff,       marker_in;
   logic        lamp_ff,         lamp_in;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic          req_accept;
   logic          csr_write;
   csr_index_type csr_index;
   req_kind_type  req_kind;
   logic [31:0]   span_product;
   logic [15:0]   period_low;
   logic [7:0]    teeth_next;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[3:2]);

   always_comb begin
      unique case (csr_index)
         CSR_MIN_TEETH:   csr_prdata = 32'(min_teeth_ff);
         CSR_MARKER_ON:   csr_prdata = 32'(marker_on_ff);
         CSR_MARKER_OFF:  csr_prdata = 32'(marker_off_ff);
         CSR_MULT_RELOAD: csr_prdata = 32'(init_reload_ff);
         default:         csr_prdata = 32'd0;
      endcase
   end

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_accept = req_tvalid & req_tready;
   assign req_kind   = req_kind_type'(req_tuser);

   // Tooth period over the overflows; only its low half feeds the reload.
   assign span_product = 32'(CAPTURE_SPAN) * 32'(overflow_ff);
   assign period_low   = req_tdata + span_product[15:0] - start_stamp_ff;
   assign teeth_next   = teeth_ff + 8'd1;

   always_comb begin
      start_stamp_in = start_stamp_ff;
      overflow_in    = overflow_ff;
      edge_phase_in  = edge_phase_ff;
      ticks_in       = ticks_ff;
      teeth_in       = teeth_ff;
      locked_in      = locked_ff;
      good_in        = good_ff;
      bad_in         = bad_ff;
      angle_in       = angle_ff;
      reload_in      = reload_ff;
      mult_count_in  = mult_count_ff;
      marker_in      = marker_ff;
      lamp_in        = lamp_ff;

      unique case (req_kind)
         REQ_EDGE: begin
            if (!edge_phase_ff) begin
               start_stamp_in = req_tdata;
               overflow_in    = 16'd0;
               edge_phase_in  = 1'b1;
            end else begin
               edge_phase_in = 1'b0;
               ticks_in      = 8'd0;
               teeth_in      = teeth_next;
               // Too many multiplied ticks in one tooth means this was the gap.
               if ({1'b0, ticks_ff} > 9'(TICK_LIMIT)) begin
                  if (teeth_next < min_teeth_ff) begin
                     bad_in    = teeth_next;
                     locked_in = 1'b0;
                     lamp_in   = 1'b1;
                  end else begin
                     good_in   = teeth_next;
                     locked_in = 1'b1;
                     lamp_in   = 1'b0;
                  end
                  teeth_in = 8'd0;
                  angle_in = 16'd0;
               end else begin
                  reload_in     = 16'(period_low / MULT_FACTOR);
                  mult_count_in = 16'd0;
               end
            end
         end
         REQ_OVERFLOW: begin
            overflow_in = overflow_ff + 16'd1;
         end
         REQ_TICK: begin
            if (mult_count_ff == reload_ff) begin
               mult_count_in = 16'd0;
               ticks_in      = ticks_ff + 8'd1;
               if (angle_ff < marker_on_ff) begin
                  marker_in = 1'b1;
               end else if (angle_ff > marker_off_ff) begin
                  marker_in = 1'b0;
               end
               angle_in = angle_ff + 16'd1;
            end else begin
               mult_count_in = mult_count_ff + 16'd1;
            end
         end
         REQ_UNUSED: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[RSP_LOCKED_LSB]                = locked_in;
      rsp_data_in[RSP_ANGLE_LSB +: 16]           = angle_in;
      rsp_data_in[RSP_MARKER_LSB]                = marker_in;
      rsp_data_in[RSP_LAMP_LSB]                  = lamp_in;
      rsp_data_in[RSP_GOOD_LSB +: 8]             = good_in;
      rsp_data_in[RSP_BAD_LSB +: 8]              = bad_in;
      rsp_data_in[RSP_DATA_W-1:RSP_BITS]         = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_teeth_ff   <= MIN_TEETH_RESET;
         marker_on_ff   <= MARKER_ON_RESET;
         marker_off_ff  <= MARKER_OFF_RESET;
         init_reload_ff <= MULT_RELOAD_RESET;
         start_stamp_ff <= 16'd0;
         overflow_ff    <= 16'd0;
         edge_phase_ff  <= 1'b0;
         ticks_ff       <= 8'd0;
         teeth_ff       <= 8'd0;
         locked_ff      <= 1'b0;
         good_ff        <= 8'd0;
         bad_ff         <= 8'd0;
         angle_ff       <= 16'd0;
         reload_ff      <= MULT_RELOAD_RESET;
         mult_count_ff  <= 16'd0;
         marker_ff      <= 1'b0;
         lamp_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rsp_data_ff    <= '0;
      end else begin
         if (req_accept) begin
            start_stamp_ff <= start_stamp_in;
            overflow_ff    <= overflow_in;
            edge_phase_ff  <= edge_phase_in;
            ticks_ff       <= ticks_in;
            teeth_ff       <= teeth_in;
            locked_ff      <= locked_in;
            good_ff        <= good_in;
            bad_ff         <= bad_in;
            angle_ff       <= angle_in;
            mult_count_ff  <= mult_count_in;
            marker_ff      <= marker_in;
            lamp_ff        <= lamp_in;
            rsp_data_ff    <= rsp_data_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         // The live reload follows a written reload register at once.
         if (csr_write && (csr_index == CSR_MULT_RELOAD)) begin
            reload_ff <= csr_pwdata[15:0];
         end else if (req_accept) begin
            reload_ff <= reload_in;
         end

         if (csr_write) begin
            unique case (csr_index)
               CSR_MIN_TEETH:   min_teeth_ff   <= csr_pwdata[7:0];
               CSR_MARKER_ON:   marker_on_ff   <= csr_pwdata[15:0];
               CSR_MARKER_OFF:  marker_off_ff  <= csr_pwdata[15:0];
               CSR_MULT_RELOAD: init_reload_ff <= csr_pwdata[15:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// File: rtl/mtcd_checker.sv
`default_nettype none

module mtcd_checker
   import mtcd_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic [1:0]            req_tuser,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic req_accept;
   assign req_accept = req_tvalid & req_tready;

   // A result that is not taken stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("held result changed");

   // Every request gives a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_tvalid)
      else $error("request produced no result");

   // An overflow request only advances the hidden overflow count.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_tuser == REQ_OVERFLOW) |=> $stable(rsp_tdata))
      else $error("overflow request changed the visible state");

   // Sync counts move only when a tooth closes on a capture edge.
   assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_tuser == REQ_TICK || req_tuser == REQ_UNUSED)
      |=> $stable(rsp_tdata[RSP_BITS-1:RSP_GOOD_LSB]))
      else $error("sync tooth counts changed without a capture edge");

endmodule

bind missing_tooth_crank_decoder mtcd_checker u_mtcd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// File: tb/tb_missing_tooth_crank_decoder.sv
module tb_missing_tooth_crank_decoder;
   import mtcd_pkg::*;

   localparam int IDLE_LIMIT   = 1000;
   localparam int RANDOM_ITEMS = 1250;

   typedef struct packed {
      logic        locked;
      logic [15:0] angle;
      logic        marker;
      logic        lamp;
      logic [7:0]  good_teeth;
      logic [7:0]  bad_teeth;
   } crank_status_type;

   // Tracks the wheel state request by request and holds the status words it predicts.
   class wheel_checker;
      logic [7:0]       min_teeth;
      logic [15:0]      on_below;
      logic [15:0]      off_above;
      logic [15:0]      init_reload;
      logic [15:0]      start_stamp;
      logic [15:0]      overflows;
      logic             period_open;
      logic [7:0]       mult_ticks;
      logic [7:0]       teeth;
      logic             locked;
      logic [7:0]       good_teeth;
      logic [7:0]       bad_teeth;
      logic [15:0]      angle;
      logic [15:0]      mult_reload;
      logic [15:0]      mult_count;
      logic             marker;
      logic             lamp;
      crank_status_type expected_status[$];
      int               failures;

      function new();
         min_teeth   = MIN_TEETH_RESET;
         on_below    = MARKER_ON_RESET;
         off_above   = MARKER_OFF_RESET;
         init_reload = MULT_RELOAD_RESET;
         start_stamp = '0;
         overflows   = '0;
         period_open = 1'b0;
         mult_ticks  = '0;
         teeth       = '0;
         locked      = 1'b0;
         good_teeth  = '0;
         bad_teeth   = '0;
         angle       = '0;
         mult_reload = init_reload;
         mult_count  = '0;
         marker      = 1'b0;
         lamp        = 1'b0;
         failures    = 0;
      endfunction

      function int pending();
         return expected_status.size();
      endfunction

      function void write_reg(csr_index_type idx, logic [31:0] value);
         case (idx)
            CSR_MIN_TEETH:  min_teeth = value[7:0];
            CSR_MARKER_ON:  on_below = value[15:0];
            CSR_MARKER_OFF: off_above = value[15:0];
            CSR_MULT_RELOAD: begin
               // The live reload follows the register at once; the counter does not.
               init_reload = value[15:0];
               mult_reload = value[15:0];
            end
            default: ;
         endcase
      endfunction

      function void apply_request(req_kind_type kind, logic [15:0] cap);
         logic [31:0]      period;
         crank_status_type s;
         case (kind)
            REQ_EDGE: begin
               if (!period_open) begin
                  start_stamp = cap;
                  overflows   = '0;
                  period_open = 1'b1;
               end else begin
                  period = 32'(cap) + 32'(CAPTURE_SPAN) * 32'(overflows)
                           - 32'(start_stamp);
                  period_open = 1'b0;
                  teeth = teeth + 8'd1;
                  if (int'(mult_ticks) > TICK_LIMIT) begin
                     if (teeth < min_teeth) begin
                        bad_teeth = teeth;
                        locked    = 1'b0;
                        lamp      = 1'b1;
                     end else begin
                        good_teeth = teeth;
                        locked     = 1'b1;
                        lamp       = 1'b0;
                     end
                     teeth = '0;
                     angle = '0;
                  end else begin
                     mult_reload = 16'(32'(period[15:0]) / MULT_FACTOR);
                     mult_count  = '0;
                  end
                  mult_ticks = '0;
               end
            end
            REQ_OVERFLOW: overflows = overflows + 16'd1;
            REQ_TICK: begin
               if (mult_count == mult_reload) begin
                  mult_count = '0;
                  mult_ticks = mult_ticks + 8'd1;
                  if (angle < on_below)
                     marker = 1'b1;
                  else if (angle > off_above)
                     marker = 1'b0;
                  angle = angle + 16'd1;
               end else begin
                  mult_count = mult_count + 16'd1;
               end
            end
            default: ;
         endcase
         s.locked     = locked;
         s.angle      = angle;
         s.marker     = marker;
         s.lamp       = lamp;
         s.good_teeth = good_teeth;
         s.bad_teeth  = bad_teeth;
         expected_status.push_back(s);
      endfunction

      function void compare(string field, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            failures++;
         end
      endfunction

      function void check_status(logic [RSP_DATA_W-1:0] word);
         crank_status_type want;
         if (expected_status.size() == 0) begin
            $error("status word arrived with no request pending");
            failures++;
            return;
         end
         want = expected_status.pop_front();
         compare("sync_locked", 16'(want.locked), 16'(word[RSP_LOCKED_LSB]));
         compare("crank_angle", want.angle, word[RSP_ANGLE_LSB +: 16]);
         compare("marker_level", 16'(want.marker), 16'(word[RSP_MARKER_LSB]));
         compare("check_lamp", 16'(want.lamp), 16'(word[RSP_LAMP_LSB]));
         compare("good_sync_teeth", 16'(want.good_teeth), 16'(word[RSP_GOOD_LSB +: 8]));
         compare("bad_sync_teeth", 16'(want.bad_teeth), 16'(word[RSP_BAD_LSB +: 8]));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [3:0]            csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   wheel_checker wheel = new();
   int send_idle_pct = 0;
   int stall_pct = 0;
   int items_sent = 0;
   int idle_cycles = 0;

   int phase_min[4]    = '{4, 0, 255, 8};
   int phase_on[4]     = '{10, 0, 65535, 30};
   int phase_off[4]    = '{20, 0, 65535, 5};
   int phase_reload[4] = '{3, 0, 1, 65535};
   int phase_idle[4]   = '{0, 53, 0, 34};
   int phase_stall[4]  = '{0, 0, 53, 34};

   missing_tooth_crank_decoder uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         wheel.check_status(rsp_tdata);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the request is taken,
   // leaving req_tvalid high so back-to-back requests need no bubble.
   task automatic send_request(req_kind_type kind, logic [15:0] cap);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= cap;
      do @(posedge clock); while (!req_tready);
      wheel.apply_request(kind, cap);
      if (kind != REQ_UNUSED)
         items_sent++;
      @(negedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      wheel.write_reg(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (wheel.pending() != 0)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // One tooth: an opening edge, base ticks, an overflow if it wraps, a closing edge.
   // A reload below 8 sizes the tick count so a gap tooth lands above the limit.
   task automatic run_tooth(bit is_gap);
      logic [15:0] stamp;
      int          span;
      int          step;
      int          ticks;
      stamp = 16'($urandom);
      span  = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(31);
      step  = (wheel.mult_reload < 8) ? int'(wheel.mult_reload) + 1 : 1;
      ticks = step * (is_gap ? $urandom_range(18, 21) : $urandom_range(1, 12));
      send_request(REQ_EDGE, stamp);
      repeat (ticks) send_request(REQ_TICK, 16'($urandom));
      if (int'(stamp) + span > 65535)
         send_request(REQ_OVERFLOW, 16'($urandom));
      send_request(REQ_EDGE, stamp + 16'(span));
   endtask

   // For a threshold up to 10, tooth counts straddle it so good and bad syncs occur.
   task automatic run_revolution();
      int teeth;
      if (wheel.min_teeth <= 10)
         teeth = int'(wheel.min_teeth) - 2 + $urandom_range(2);
      else
         teeth = $urandom_range(1, 10);
      if (teeth < 0)
         teeth = 0;
      repeat (teeth) run_tooth(1'b0);
      run_tooth(1'b1);
      if ($urandom_range(3) == 0)
         repeat ($urandom_range(1, 3))
            send_request(req_kind_type'($urandom_range(3)), 16'($urandom));
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_request(REQ_UNUSED, 16'hFFFF);
      send_request(REQ_TICK, 16'h0000);
      send_request(REQ_OVERFLOW, 16'h0000);
      send_request(REQ_EDGE, 16'hFFFF);
      send_request(REQ_OVERFLOW, 16'hFFFF);
      send_request(REQ_OVERFLOW, 16'h0000);
      // Two overflows make the period 65537, whose low bits give a reload of zero.
      send_request(REQ_EDGE, 16'h0000);
      send_request(REQ_EDGE, 16'h5A5A);
      repeat (17) send_request(REQ_TICK, 16'hA5A5);
      // Seventeen multiplied ticks make this a gap after too few teeth.
      send_request(REQ_EDGE, 16'h5A5A);

      for (int phase = 0; phase < 4; phase++) begin
         wait_drained();
         write_register(CSR_MIN_TEETH, 32'(phase_min[phase]));
         write_register(CSR_MARKER_ON, 32'(phase_on[phase]));
         write_register(CSR_MARKER_OFF, 32'(phase_off[phase]));
         write_register(CSR_MULT_RELOAD, 32'(phase_reload[phase]));
         send_idle_pct = phase_idle[phase];
         stall_pct     = phase_stall[phase];
         while (items_sent < RANDOM_ITEMS * (phase + 1) / 4)
            run_revolution();
      end

      req_tvalid <= 1'b0;
      while (wheel.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      if (wheel.failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// File: missing_tooth_crank_decoder.f
rtl/mtcd_pkg.sv
rtl/missing_tooth_crank_decoder.sv
rtl/mtcd_checker.sv
tb/tb_missing_tooth_crank_decoder.sv
